// File: sv/hlvn_pkg.sv
// ----------------------------------------------------------------------------
// hlvn_pkg
// Shared constants and helpers for the hashed lattice value noise pipeline.
// ----------------------------------------------------------------------------
package hlvn_pkg;

	localparam int LAT_FRAC   = 24;
	localparam int VALUE_W    = 24;
	localparam int COORD_W    = 32;
	localparam int SCALE_W    = 24;
	localparam int SALT_W     = 32;

	localparam logic [31:0] HASH_KX = 32'h9e3779b9;
	localparam logic [31:0] HASH_KY = 32'h85ebca6b;
	localparam logic [31:0] HASH_M1 = 32'h7feb352d;
	localparam logic [31:0] HASH_M2 = 32'h846ca68b;

	localparam logic [0:0] REG_INVERSE_SCALE = 1'b0;
	localparam logic [0:0] REG_SALT          = 1'b1;

	typedef logic [VALUE_W-1:0] value_t;

endpackage

// File: sv/hashed_lattice_value_noise.sv
// ----------------------------------------------------------------------------
// hashed_lattice_value_noise
// 2D value noise over a hashed integer lattice, fully pipelined.
// ----------------------------------------------------------------------------
// channel    direction  fields
// s_axis     in         tdata: point_x[31:0], point_y[63:32]
// m_axis     out        tdata: noise_value[23:0]
// cfg        in         index 0 inverse_scale, 1 salt
//
// One request enters per cycle while the output is not stalled; the stages are
// scale multiply, hash pipeline, two interpolation steps, output register.
// The whole pipeline advances together and holds while the output waits.
// Reset clears valid bits and restores register defaults.
// ----------------------------------------------------------------------------
module hashed_lattice_value_noise #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // point_x, point_y
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // noise_value
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import hlvn_pkg::*;

	localparam int DEPTH = 11;
	localparam int SHIFT = LAT_FRAC - FRAC_BITS;

	logic [SCALE_W-1:0] inverse_scale_q;
	logic [SALT_W-1:0]  salt_q;
	logic [DEPTH-1:0]   vld_q;
	logic               en;

	assign en            = !vld_q[DEPTH-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_scale_q <= SCALE_W'(2849);
			salt_q          <= SALT_W'(7);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INVERSE_SCALE: inverse_scale_q <= cfg_data[SCALE_W-1:0];
				REG_SALT:          salt_q <= cfg_data;
				default:           salt_q <= salt_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
		end
	end

	// stage 1: scale multiply
	logic signed [56:0] px_s1, py_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= $signed(s_axis_tdata[31:0]) * $signed({1'b0, inverse_scale_q});
			py_s1 <= $signed(s_axis_tdata[63:32]) * $signed({1'b0, inverse_scale_q});
		end
	end

	logic [31:0] cx, cy, cx1, cy1;
	logic [FRAC_BITS-1:0] fx, fy;
	assign cx  = px_s1[LAT_FRAC +: 32];
	assign cy  = py_s1[LAT_FRAC +: 32];
	assign cx1 = cx + 32'd1;
	assign cy1 = cy + 32'd1;
	assign fx  = px_s1[SHIFT +: FRAC_BITS];
	assign fy  = py_s1[SHIFT +: FRAC_BITS];

	// stages 2..6: hashes; smoothstep then delay to match
	value_t va, vb, vc, vd;
	hlvn_hash u_ha (.clk, .en, .cx(cx),  .cy(cy),  .salt(salt_q), .value(va));
	hlvn_hash u_hb (.clk, .en, .cx(cx1), .cy(cy),  .salt(salt_q), .value(vb));
	hlvn_hash u_hc (.clk, .en, .cx(cx),  .cy(cy1), .salt(salt_q), .value(vc));
	hlvn_hash u_hd (.clk, .en, .cx(cx1), .cy(cy1), .salt(salt_q), .value(vd));

	logic [FRAC_BITS-1:0] sx, sy, sx_s5, sy_s5, sx_s6, sy_s6, sy_s7, sy_s8;
	hlvn_smooth #(.FRAC_BITS(FRAC_BITS)) u_sx (.clk, .en, .t(fx), .s(sx));
	hlvn_smooth #(.FRAC_BITS(FRAC_BITS)) u_sy (.clk, .en, .t(fy), .s(sy));

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s5 <= sx;
			sy_s5 <= sy;
			sx_s6 <= sx_s5;
			sy_s6 <= sy_s5;
			sy_s7 <= sy_s6;
			sy_s8 <= sy_s7;
		end
	end

	// stages 7..8: x lerps; 9..10: y lerp
	value_t top, bottom, res;
	hlvn_lerp #(.FRAC_BITS(FRAC_BITS)) u_lt (.clk, .en, .lo(va), .hi(vb), .s(sx_s6), .r(top));
	hlvn_lerp #(.FRAC_BITS(FRAC_BITS)) u_lb (.clk, .en, .lo(vc), .hi(vd), .s(sx_s6),
		.r(bottom));
	hlvn_lerp #(.FRAC_BITS(FRAC_BITS)) u_ly (.clk, .en, .lo(top), .hi(bottom), .s(sy_s8),
		.r(res));

	value_t out_s11;
	always_ff @(posedge clk) begin
		if (en) begin
			out_s11 <= res;
		end
	end

	assign m_axis_tdata = out_s11;
endmodule

// File: sv/hlvn_hash.sv
// ----------------------------------------------------------------------------
// hlvn_hash
// Pipelined multiply-xorshift corner hash, five register stages.
// ----------------------------------------------------------------------------
module hlvn_hash (
	input  logic                 clk,
	input  logic                 en,
	input  logic [31:0]          cx,
	input  logic [31:0]          cy,
	input  logic [31:0]          salt,
	output hlvn_pkg::value_t     value
);
	import hlvn_pkg::*;

	logic [31:0] hx_s1, hy_s1, salt_s1;
	logic [31:0] h_s2, m_s3, g_s4;
	logic [31:0] h2, h4;
	value_t      v_s5;

	always_comb begin
		h2 = hx_s1 ^ hy_s1 ^ salt_s1;
		h2 = h2 ^ (h2 >> 16);
		h4 = m_s3 ^ (m_s3 >> 15);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hx_s1   <= cx * HASH_KX;
			hy_s1   <= cy * HASH_KY;
			salt_s1 <= salt;
			h_s2    <= h2;
			m_s3    <= h_s2 * HASH_M1;
			g_s4    <= h4 * HASH_M2;
			v_s5    <= VALUE_W'(g_s4 ^ (g_s4 >> 16));
		end
	end

	assign value = v_s5;
endmodule

// File: sv/hlvn_lerp.sv
// ----------------------------------------------------------------------------
// hlvn_lerp
// One registered interpolation step with saturation.
// ----------------------------------------------------------------------------
module hlvn_lerp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  hlvn_pkg::value_t     lo,
	input  hlvn_pkg::value_t     hi,
	input  logic [FRAC_BITS-1:0] s,
	output hlvn_pkg::value_t     r
);
	import hlvn_pkg::*;

	logic                         up_q;
	value_t                       lo_q;
	logic [VALUE_W+FRAC_BITS-1:0] prod_q;
	value_t                       diff;
	logic [VALUE_W:0]             sum;
	value_t                       corr;

	always_comb begin
		diff = (hi >= lo) ? (hi - lo) : (lo - hi);
		corr = VALUE_W'(prod_q >> FRAC_BITS);
		if (up_q) begin
			sum = {1'b0, lo_q} + {1'b0, corr};
		end else begin
			sum = {1'b0, lo_q} - {1'b0, corr};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			up_q   <= hi >= lo;
			lo_q   <= lo;
			prod_q <= (VALUE_W + FRAC_BITS)'(diff) * (VALUE_W + FRAC_BITS)'(s);
			r      <= sum[VALUE_W] ? {VALUE_W{1'b1}} : sum[VALUE_W-1:0];
		end
	end
endmodule

// File: sv/hlvn_smooth.sv
// ----------------------------------------------------------------------------
// hlvn_smooth
// Pipelined smoothstep t*t*(3-2t) on a fixed-point fraction.
// ----------------------------------------------------------------------------
module hlvn_smooth #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] t,
	output logic [FRAC_BITS-1:0] s
);
	import hlvn_pkg::*;

	logic [FRAC_BITS-1:0] t2_s1;
	logic [FRAC_BITS+1:0] k_s1;
	logic [2*FRAC_BITS+1:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			t2_s1 <= FRAC_BITS'(((2*FRAC_BITS)'(t) * (2*FRAC_BITS)'(t)) >> FRAC_BITS);
			k_s1  <= (FRAC_BITS+2)'(3) * (FRAC_BITS+2)'(1 << FRAC_BITS)
				- ((FRAC_BITS+2)'(t) << 1);
			p_s2  <= (2*FRAC_BITS+2)'(t2_s1) * (2*FRAC_BITS+2)'(k_s1);
			s     <= FRAC_BITS'(p_s2 >> FRAC_BITS);
		end
	end
endmodule

// File: tb/hashed_lattice_value_noise_tb.sv
// ----------------------------------------------------------------------------
// hashed_lattice_value_noise_tb
// Streams world points through the value noise pipeline under bursty input
// and a stalling output, predicts each noise value in the bench and compares
// results in order. Walks several scale and salt settings, including extremes.
// ----------------------------------------------------------------------------
module hashed_lattice_value_noise_tb;
	import hlvn_pkg::*;

	class noise_scoreboard;
		logic [23:0] scale;
		logic [31:0] salt;
		value_t pending[$];
		int errors;
		int checked;

		function new();
			scale = 24'd2849;
			salt = 32'd7;
			errors = 0;
			checked = 0;
		endfunction

		function logic [23:0] corner(logic [31:0] cx, logic [31:0] cy);
			logic [31:0] h;
			h = cx * 32'h9e3779b9;
			h = h ^ (cy * 32'h85ebca6b);
			h = h ^ salt;
			h = h ^ (h >> 16);
			h = h * 32'h7feb352d;
			h = h ^ (h >> 15);
			h = h * 32'h846ca68b;
			h = h ^ (h >> 16);
			return h[23:0];
		endfunction

		function logic [63:0] smooth(logic [63:0] t);
			logic [63:0] t2;
			logic [63:0] k;
			t2 = (t * t) >> 16;
			k = (64'd3 << 16) - 2 * t;
			return (t2 * k) >> 16;
		endfunction

		function logic [63:0] blend(logic [63:0] lo, logic [63:0] hi, logic [63:0] s);
			logic [63:0] r;
			if (hi >= lo) begin
				r = lo + (((hi - lo) * s) >> 16);
			end else begin
				r = lo - (((lo - hi) * s) >> 16);
			end
			if (r > 64'hffffff) begin
				r = 64'hffffff;
			end
			return r;
		endfunction

		function void note_point(logic [31:0] px, logic [31:0] py);
			logic [63:0] p;
			logic [31:0] cx, cy;
			logic [63:0] sx, sy, top, bot;
			p = {{32{px[31]}}, px} * {40'd0, scale};
			cx = p[55:24];
			sx = smooth({48'd0, p[23:8]});
			p = {{32{py[31]}}, py} * {40'd0, scale};
			cy = p[55:24];
			sy = smooth({48'd0, p[23:8]});
			top = blend(corner(cx, cy), corner(cx + 1, cy), sx);
			bot = blend(corner(cx, cy + 1), corner(cx + 1, cy + 1), sx);
			p = blend(top, bot, sy);
			pending = {pending, p[23:0]};
		endfunction

		function void check_noise(logic [23:0] got);
			value_t want;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected noise result, expected none, actual %h", $time, got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: noise_value mismatch, expected %h, actual %h", $time, want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = REG_INVERSE_SCALE;
	logic [31:0] cfg_data = '0;

	noise_scoreboard sb = new();
	logic long_hold = 1'b0;
	int hold_phase = 0;
	int sent = 0;
	int idle_span = 0;

	hashed_lattice_value_noise dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sb.note_point(s_axis_tdata[31:0], s_axis_tdata[63:32]);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			sb.check_noise(m_axis_tdata);
		end
	end

	// stall pattern: quiet stretches, random stalls, rhythmic stalls, long hold
	always @(posedge clk) begin
		hold_phase <= hold_phase + 1;
		if (long_hold) begin
			m_axis_tready <= 1'b0;
		end else if (hold_phase[9:8] == 2'd0) begin
			m_axis_tready <= 1'b1;
		end else if (hold_phase[9:8] == 2'd1) begin
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		end else if (hold_phase[9:8] == 2'd2) begin
			m_axis_tready <= (hold_phase % 3 != 0);
		end else begin
			m_axis_tready <= ($urandom_range(0, 1) != 0);
		end
	end

	initial begin
		wait (sent >= 400);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (200) @(posedge clk);
		long_hold <= 1'b0;
	end

	task automatic send_point(logic [31:0] px, logic [31:0] py);
		if (idle_span == 0) begin
			if ($urandom_range(0, 2) == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			idle_span = $urandom_range(1, 30);
		end
		idle_span--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {py, px};
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_INVERSE_SCALE) begin
			sb.scale = val[23:0];
		end else begin
			sb.salt = val;
		end
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		logic [31:0] v;
		v = $urandom();
		case (mode)
			0: return v;
			1: return {{20{v[31]}}, v[11:0]};
			2: return {{8{v[31]}}, v[23:0]};
			default: return v ^ 32'h80000000;
		endcase
	endfunction

	initial begin
		logic [23:0] scales[6];
		logic [31:0] salts[6];
		scales = '{24'd2849, 24'd1, 24'hffffff, 24'h010000, 24'd0, 24'h00ffff};
		salts = '{32'd7, 32'd0, 32'hffffffff, 32'h5a5a5a5a, 32'h12345678, 32'h80000001};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_point(32'h0, 32'h0);
		send_point(32'h7fffffff, 32'h7fffffff);
		send_point(32'h80000000, 32'h80000000);
		send_point(32'hffffffff, 32'h00000001);
		send_point(32'h80000000, 32'h7fffffff);
		send_point(32'h00001700, 32'hffffe900);
		send_point(32'h000016ff, 32'h00002e00);
		drain();
		write_reg(REG_INVERSE_SCALE, 32'hffffff);
		write_reg(REG_SALT, 32'hffffffff);
		send_point(32'h7fffffff, 32'h80000000);
		send_point(32'h80000000, 32'hffffffff);
		send_point(32'h00000100, 32'h000000ff);
		send_point(32'hffffff00, 32'h00000080);
		drain();
		write_reg(REG_INVERSE_SCALE, 32'h0);
		send_point(32'h12345678, 32'h9abcdef0);
		send_point(32'h7fffffff, 32'h80000000);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_INVERSE_SCALE, {8'd0, scales[ph]});
			write_reg(REG_SALT, salts[ph]);
			for (int i = 0; i < 256; i++) begin
				send_point(rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)));
			end
			drain();
		end

		$display("Sent %0d points, checked %0d noise results over six scale/salt settings",
			sent, sb.checked);
		$display("Directed extremes, zero scale and lattice wrap included");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule

// File: sim.f
sv/hlvn_pkg.sv
sv/hlvn_hash.sv
sv/hlvn_lerp.sv
sv/hlvn_smooth.sv
sv/hashed_lattice_value_noise.sv
tb/hashed_lattice_value_noise_tb.sv
